FILE: rtl/xcrc_pkg.sv
// ----------------------------------------------------------------------------
// xcrc_pkg
// Shared types, codes and the CRC-16 byte fold for the XMODEM-CRC sender.
// ----------------------------------------------------------------------------
`default_nettype none

package xcrc_pkg;

    // Packet geometry
    localparam int PACKET_BYTES = 128;
    localparam int CNT_W        = $clog2(PACKET_BYTES);

    // Input function codes
    localparam logic [1:0] FN_PAYLOAD = 2'd0;
    localparam logic [1:0] FN_RX      = 2'd1;
    localparam logic [1:0] FN_END     = 2'd2;
    localparam logic [1:0] FN_TIMEOUT = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ACKED   = 3'd1;
    localparam logic [2:0] ST_BAD     = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;
    localparam logic [2:0] ST_MISUSE  = 3'd5;

    // Link bytes
    localparam logic [7:0] SOH_BYTE = 8'h01;
    localparam logic [7:0] EOT_BYTE = 8'h04;
    localparam logic [7:0] ACK_BYTE = 8'h06;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Result burst: up to four beats per input item
    localparam int MAX_BEATS  = 4;
    localparam int BEAT_IDX_W = $clog2(MAX_BEATS);

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [2:0] status;
    } beat_t;

    typedef struct packed {
        beat_t [MAX_BEATS-1:0]  beats;
        logic [BEAT_IDX_W-1:0]  last_idx;
    } burst_t;

    // CRC-16/XMODEM, one byte folded MSB first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                             input logic [7:0]  byte_in);
        logic [15:0] crc;
        crc = crc_in ^ {byte_in, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/xcrc_item_if.sv
// ----------------------------------------------------------------------------
// xcrc_item_if
// Input channel: function code and data byte with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface xcrc_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data;

    modport source (output valid, func, data, input ready);
    modport sink   (input valid, func, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/xcrc_result_if.sv
// ----------------------------------------------------------------------------
// xcrc_result_if
// Result channel: link byte, status and end-of-burst mark with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface xcrc_result_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] status;
    logic       last;

    modport source (output valid, tx_valid, tx_byte, status, last, input ready);
    modport sink   (input valid, tx_valid, tx_byte, status, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/xcrc_framer.sv
// ----------------------------------------------------------------------------
// xcrc_framer
// Input register, protocol state and CRC; turns one item into one burst.
// ----------------------------------------------------------------------------
`default_nettype none

module xcrc_framer
    import xcrc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    xcrc_item_if.sink   item,
    output burst_t      burst,
    output logic        burst_valid,
    input  wire logic   burst_ready
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_WACK = 3'd1,
        PH_WEOT = 3'd2,
        PH_DONE = 3'd3,
        PH_ERR  = 3'd4
    } phase_t;

    phase_t             phase_reg,  phase_next;
    logic [7:0]         block_reg,  block_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [15:0]        crc_reg,    crc_next;
    logic               full_reg,   full_next;
    logic [1:0]         func_reg;
    logic [7:0]         data_reg;

    logic               take_item;
    logic               load;
    logic [15:0]        crc_folded;

    // Input register handshake
    assign take_item   = item.valid && item.ready;
    assign load        = full_reg && burst_ready;
    assign item.ready  = !full_reg || burst_ready;
    assign burst_valid = full_reg;

    always_comb
    begin
        full_next = full_reg;
        if (take_item) begin
            full_next = 1'b1;
        end
        else if (load) begin
            full_next = 1'b0;
        end
    end

    // Item payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take_item) begin
            func_reg <= item.func;
            data_reg <= item.data;
        end
    end

    // CRC restarts at the first byte of a packet
    assign crc_folded = crc_fold((count_reg == '0) ? 16'h0000 : crc_reg, data_reg);

    // Burst build and next state
    always_comb
    begin
        phase_next = phase_reg;
        block_next = block_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        burst      = '0;

        if (phase_reg != PH_IDLE && phase_reg != PH_WACK && phase_reg != PH_WEOT) begin
            burst.beats[0].status = ST_MISUSE;
        end
        else begin
            unique case (func_reg)
                FN_PAYLOAD:
                begin
                    if (phase_reg != PH_IDLE) begin
                        burst.beats[0].status = ST_MISUSE;
                    end
                    else if (count_reg == '0) begin
                        // first byte: header then data
                        burst.beats[0] = '{1'b1, SOH_BYTE,   ST_OK};
                        burst.beats[1] = '{1'b1, block_reg,  ST_OK};
                        burst.beats[2] = '{1'b1, ~block_reg, ST_OK};
                        burst.beats[3] = '{1'b1, data_reg,   ST_OK};
                        burst.last_idx = BEAT_IDX_W'(3);
                        crc_next       = crc_folded;
                        count_next     = count_reg + 1'b1;
                    end
                    else if (count_reg == CNT_W'(PACKET_BYTES - 1)) begin
                        // last byte: data then CRC
                        burst.beats[0] = '{1'b1, data_reg,          ST_OK};
                        burst.beats[1] = '{1'b1, crc_folded[15:8],  ST_OK};
                        burst.beats[2] = '{1'b1, crc_folded[7:0],   ST_OK};
                        burst.last_idx = BEAT_IDX_W'(2);
                        crc_next       = crc_folded;
                        count_next     = '0;
                        phase_next     = PH_WACK;
                    end
                    else begin
                        burst.beats[0] = '{1'b1, data_reg, ST_OK};
                        crc_next       = crc_folded;
                        count_next     = count_reg + 1'b1;
                    end
                end
                FN_RX:
                begin
                    if (phase_reg == PH_WACK) begin
                        if (data_reg == ACK_BYTE) begin
                            block_next            = block_reg + 1'b1;
                            crc_next              = '0;
                            phase_next            = PH_IDLE;
                            burst.beats[0].status = ST_ACKED;
                        end
                        else begin
                            phase_next            = PH_ERR;
                            burst.beats[0].status = ST_BAD;
                        end
                    end
                    else if (phase_reg == PH_WEOT) begin
                        if (data_reg == ACK_BYTE) begin
                            phase_next            = PH_DONE;
                            burst.beats[0].status = ST_DONE;
                        end
                        else begin
                            phase_next            = PH_ERR;
                            burst.beats[0].status = ST_BAD;
                        end
                    end
                    else begin
                        burst.beats[0].status = ST_OK;
                    end
                end
                FN_END:
                begin
                    if (phase_reg == PH_IDLE && count_reg == '0) begin
                        phase_next     = PH_WEOT;
                        burst.beats[0] = '{1'b1, EOT_BYTE, ST_OK};
                    end
                    else begin
                        burst.beats[0].status = ST_MISUSE;
                    end
                end
                FN_TIMEOUT:
                begin
                    if (phase_reg == PH_WACK || phase_reg == PH_WEOT) begin
                        phase_next            = PH_ERR;
                        burst.beats[0].status = ST_TIMEOUT;
                    end
                    else begin
                        burst.beats[0].status = ST_OK;
                    end
                end
                default:
                begin
                    burst.beats[0].status = ST_OK;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            full_reg  <= 1'b0;
            phase_reg <= PH_IDLE;
            block_reg <= 8'd1;
            count_reg <= '0;
            crc_reg   <= '0;
        end
        else begin
            full_reg <= full_next;
            if (load) begin
                phase_reg <= phase_next;
                block_reg <= block_next;
                count_reg <= count_next;
                crc_reg   <= crc_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/xcrc_burst_out.sv
// ----------------------------------------------------------------------------
// xcrc_burst_out
// Result register: holds one burst and sends its beats one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module xcrc_burst_out
    import xcrc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire burst_t     burst,
    input  wire logic       burst_valid,
    output logic            burst_ready,
    xcrc_result_if.source   result
);

    burst_t                 burst_reg;
    logic                   busy_reg, busy_next;
    logic [BEAT_IDX_W-1:0]  idx_reg,  idx_next;
    beat_t                  beat;
    logic                   is_last;
    logic                   take;
    logic                   done;
    logic                   load;

    // Current beat
    assign beat    = burst_reg.beats[idx_reg];
    assign is_last = (idx_reg == burst_reg.last_idx);

    assign result.valid    = busy_reg;
    assign result.tx_valid = beat.tx_valid;
    assign result.tx_byte  = beat.tx_byte;
    assign result.status   = beat.status;
    assign result.last     = is_last;

    // Free when empty or when the final beat leaves this cycle
    assign take        = busy_reg && result.ready;
    assign done        = take && is_last;
    assign burst_ready = !busy_reg || done;
    assign load        = burst_valid && burst_ready;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (done) begin
            busy_next = 1'b0;
        end
        else if (take) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            burst_reg <= burst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/xmodem_crc_packet_sender.sv
// ----------------------------------------------------------------------------
// xmodem_crc_packet_sender
// XMODEM-CRC transmit framer: header, payload pass-through, CRC-16, EOT.
// ----------------------------------------------------------------------------
//  port    | dir  | beat contents
//  --------+------+-----------------------------------------------
//  item    | in   | func (2), data (8)
//  result  | out  | tx_valid (1), tx_byte (8), status (3), last (1)
//
//  Each item yields a burst of 1 to 4 result beats: 4 for the first
//  byte of a packet, 3 for the last, 1 otherwise. The output register
//  sends one beat per cycle while result.ready is high. An item waits
//  in the input register until its burst loads into the output register;
//  the next item is taken while beats drain.
//  Reset (rst_n low, async): idle, block number 1, byte count and CRC 0.
//  result.ready low holds the current beat; item.ready drops once the
//  input register holds an item that the output register cannot take.
// ----------------------------------------------------------------------------
`default_nettype none

module xmodem_crc_packet_sender
    import xcrc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    xcrc_item_if.sink       item,
    xcrc_result_if.source   result
);

    burst_t burst;
    logic   burst_valid;
    logic   burst_ready;

    xcrc_framer u_framer (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .burst       (burst),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready)
    );

    xcrc_burst_out u_burst_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst       (burst),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .result      (result)
    );

    // Idle beats carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.tx_valid) |-> (result.tx_byte == 8'h00))
        else $error("non-link beat carries a byte");

    // Link bytes only go out with ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.tx_valid) |-> (result.status == ST_OK))
        else $error("link byte with non-ok status");

    // A burst does not break off before its last beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && !result.last) |=> result.valid)
        else $error("burst ended without last beat");

    // A pending burst is not taken while the current one still has beats left
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.last) |-> !burst_ready)
        else $error("burst loaded mid-burst");

endmodule

`default_nettype wire

FILE: tb/tb_xmodem_crc_packet_sender.sv
// ----------------------------------------------------------------------------
// tb_xmodem_crc_packet_sender
// Self-checking bench for the XMODEM-CRC framer. A table of directed items
// runs first, then random packets with random content and light noise, and
// the run ends in one randomly chosen closing exchange (final ACK, bad
// response or timeout) followed by a few items in the closed state. Every
// result beat is checked field by field against an in-bench framer model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_xmodem_crc_packet_sender;
    timeunit 1ns;
    timeprecision 1ps;

    import xcrc_pkg::*;

    localparam int         NUM_ROWS     = 15;
    localparam int         RANDOM_ITEMS = 100;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         LIMIT_NS     = 5_000_000;
    localparam logic [7:0] NAK_BYTE     = 8'h15;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_ACK,
        PH_WAIT_EOT_ACK,
        PH_DONE,
        PH_ERROR
    } framer_phase_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [2:0] status;
        logic       last;
    } link_beat_t;

    // One directed row; reps > 1 sends that many payload bytes of random data
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data;
        logic [7:0] reps;
        logic       typed;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [2:0] status;
    } stim_row_t;

    logic clk;
    logic rst_n;

    xcrc_item_if   item_bus();
    xcrc_result_if result_bus();

    xmodem_crc_packet_sender u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    // Framer model state
    framer_phase_t model_phase;
    logic [7:0]    model_block;
    logic [7:0]    model_count;
    logic [15:0]   model_crc;

    link_beat_t step_beats[$];
    link_beat_t expected_beats[$];
    stim_row_t  directed_rows [0:NUM_ROWS-1];

    int err_count = 0;
    int beat_num  = 0;
    int src_items = 0;
    bit src_calm  = 1'b0;
    bit snk_calm  = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(LIMIT_NS);
        $display("tb_xmodem_crc_packet_sender: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    // CRC-16/XMODEM, bit-serial form with data bit fed into the feedback
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic void queue_beat(input logic v, input logic [7:0] b,
                                       input logic [2:0] s);
        step_beats.push_back('{v, b, s, 1'b0});
    endfunction

    // Apply one item to the model; the beats it causes land in step_beats
    function automatic void advance_framer(input logic [1:0] fn,
                                           input logic [7:0] dat);
        step_beats.delete();
        if (model_phase == PH_DONE || model_phase == PH_ERROR)
        begin
            queue_beat(1'b0, 8'h00, ST_MISUSE);
        end
        else
        begin
            case (fn)
                FN_PAYLOAD:
                begin
                    if (model_phase != PH_IDLE)
                    begin
                        queue_beat(1'b0, 8'h00, ST_MISUSE);
                    end
                    else
                    begin
                        // packet header ahead of the first byte
                        if (model_count == 8'd0)
                        begin
                            model_crc = 16'h0000;
                            queue_beat(1'b1, SOH_BYTE, ST_OK);
                            queue_beat(1'b1, model_block, ST_OK);
                            queue_beat(1'b1, ~model_block, ST_OK);
                        end
                        queue_beat(1'b1, dat, ST_OK);
                        model_crc   = crc16_byte(model_crc, dat);
                        model_count = model_count + 8'd1;
                        // trailer after the last byte
                        if (model_count == 8'(PACKET_BYTES))
                        begin
                            queue_beat(1'b1, model_crc[15:8], ST_OK);
                            queue_beat(1'b1, model_crc[7:0], ST_OK);
                            model_count = 8'd0;
                            model_phase = PH_WAIT_ACK;
                        end
                    end
                end
                FN_RX:
                begin
                    if (model_phase == PH_WAIT_ACK && dat == ACK_BYTE)
                    begin
                        model_block = model_block + 8'd1;
                        model_crc   = 16'h0000;
                        model_phase = PH_IDLE;
                        queue_beat(1'b0, 8'h00, ST_ACKED);
                    end
                    else if (model_phase == PH_WAIT_EOT_ACK && dat == ACK_BYTE)
                    begin
                        model_phase = PH_DONE;
                        queue_beat(1'b0, 8'h00, ST_DONE);
                    end
                    else if (model_phase != PH_IDLE)
                    begin
                        model_phase = PH_ERROR;
                        queue_beat(1'b0, 8'h00, ST_BAD);
                    end
                    else
                    begin
                        queue_beat(1'b0, 8'h00, ST_OK);
                    end
                end
                FN_END:
                begin
                    if (model_phase == PH_IDLE && model_count == 8'd0)
                    begin
                        model_phase = PH_WAIT_EOT_ACK;
                        queue_beat(1'b1, EOT_BYTE, ST_OK);
                    end
                    else
                    begin
                        queue_beat(1'b0, 8'h00, ST_MISUSE);
                    end
                end
                default:
                begin
                    if (model_phase != PH_IDLE)
                    begin
                        model_phase = PH_ERROR;
                        queue_beat(1'b0, 8'h00, ST_TIMEOUT);
                    end
                    else
                    begin
                        queue_beat(1'b0, 8'h00, ST_OK);
                    end
                end
            endcase
        end
        step_beats[step_beats.size()-1].last = 1'b1;
    endfunction

    // Payload data, weighted toward the all-zero and all-one bytes
    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Drive one item, wait until it is taken, then book its expected results
    task automatic send_item(input logic [1:0] fn, input logic [7:0] dat,
                             input bit typed, input link_beat_t typed_beat);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.func  <= fn;
        item_bus.data  <= dat;
        do
            @(posedge clk);
        while (!(item_bus.valid === 1'b1 && item_bus.ready === 1'b1));
        advance_framer(fn, dat);
        if (typed)
        begin
            expected_beats.push_back(typed_beat);
        end
        else
        begin
            foreach (step_beats[i])
            begin
                expected_beats.push_back(step_beats[i]);
            end
        end
        src_items++;
        if (src_items % 32 == 0)
        begin
            src_calm = ($urandom_range(0, 3) == 0);
        end
    endtask

    // Result sink with random stalls
    initial
    begin
        int stall;
        int beats_taken;
        beats_taken = 0;
        forever
        begin
            stall = snk_calm ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_bus.valid === 1'b1 && result_bus.ready === 1'b1));
            beats_taken++;
            if (beats_taken % 32 == 0)
            begin
                snk_calm = ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        link_beat_t got;
        link_beat_t want;
        if (rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        begin
            got = '{result_bus.tx_valid, result_bus.tx_byte,
                    result_bus.status, result_bus.last};
            if (expected_beats.size() == 0)
            begin
                report_mismatch($sformatf(
                    "beat %0d unexpected: tx_valid %0b byte %02h status %0d last %0b",
                    beat_num, got.tx_valid, got.tx_byte, got.status, got.last));
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got.tx_valid !== want.tx_valid)
                begin
                    report_mismatch($sformatf("beat %0d tx_valid %0b, want %0b",
                                              beat_num, got.tx_valid, want.tx_valid));
                end
                if (got.tx_byte !== want.tx_byte)
                begin
                    report_mismatch($sformatf("beat %0d tx_byte %02h, want %02h",
                                              beat_num, got.tx_byte, want.tx_byte));
                end
                if (got.status !== want.status)
                begin
                    report_mismatch($sformatf("beat %0d status %0d, want %0d",
                                              beat_num, got.status, want.status));
                end
                if (got.last !== want.last)
                begin
                    report_mismatch($sformatf("beat %0d last %0b, want %0b",
                                              beat_num, got.last, want.last));
                end
            end
            beat_num++;
        end
    end

    // Stimulus
    initial
    begin
        stim_row_t  row;
        int         counted;
        int         pick;
        int         scen;
        logic [1:0] fn;
        logic [7:0] dat;
        logic [7:0] bad_reply;

        item_bus.valid <= 1'b0;
        item_bus.func  <= FN_PAYLOAD;
        item_bus.data  <= 8'h00;
        rst_n          <= 1'b0;

        model_phase = PH_IDLE;
        model_block = 8'd1;
        model_count = 8'd0;
        model_crc   = 16'h0000;

        // func, data, reps, typed, tx_valid, tx_byte, status
        directed_rows = '{
            // responses and timeouts with nothing awaited are ignored
            '{FN_RX,      ACK_BYTE, 8'd1,   1'b1, 1'b0, 8'h00, ST_OK},
            '{FN_TIMEOUT, 8'h00,    8'd1,   1'b1, 1'b0, 8'h00, ST_OK},
            '{FN_RX,      NAK_BYTE, 8'd1,   1'b1, 1'b0, 8'h00, ST_OK},
            // block 1: header plus first byte, then misuse mid-packet
            '{FN_PAYLOAD, 8'h00,    8'd1,   1'b0, 1'b0, 8'h00, ST_OK},
            '{FN_END,     8'hFF,    8'd1,   1'b1, 1'b0, 8'h00, ST_MISUSE},
            '{FN_TIMEOUT, 8'hFF,    8'd1,   1'b1, 1'b0, 8'h00, ST_OK},
            '{FN_PAYLOAD, 8'hFF,    8'd1,   1'b0, 1'b0, 8'h00, ST_OK},
            '{FN_PAYLOAD, 8'h80,    8'd1,   1'b0, 1'b0, 8'h00, ST_OK},
            '{FN_PAYLOAD, 8'h00,    8'd124, 1'b0, 1'b0, 8'h00, ST_OK},
            // last byte: data plus both CRC bytes
            '{FN_PAYLOAD, 8'h7F,    8'd1,   1'b0, 1'b0, 8'h00, ST_OK},
            // payload and end of data while an ACK is awaited
            '{FN_PAYLOAD, 8'h55,    8'd1,   1'b1, 1'b0, 8'h00, ST_MISUSE},
            '{FN_END,     8'h00,    8'd1,   1'b1, 1'b0, 8'h00, ST_MISUSE},
            '{FN_RX,      ACK_BYTE, 8'd1,   1'b1, 1'b0, 8'h00, ST_ACKED},
            // block 2, full packet
            '{FN_PAYLOAD, 8'hAA,    8'd1,   1'b0, 1'b0, 8'h00, ST_OK},
            '{FN_PAYLOAD, 8'h00,    8'd127, 1'b0, 1'b0, 8'h00, ST_OK}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row = directed_rows[r];
            for (int k = 0; k < int'(row.reps); k++)
            begin
                send_item(row.func, (row.reps > 8'd1) ? pick_payload() : row.data,
                          row.typed, '{row.tx_valid, row.tx_byte, row.status, 1'b1});
            end
        end

        // Random packets: mostly well-formed traffic, some harmless noise
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            dat  = 8'($urandom);
            if (model_phase == PH_WAIT_ACK)
            begin
                if (pick < 85)
                begin
                    fn  = FN_RX;
                    dat = ACK_BYTE;
                    counted++;
                end
                else if (pick < 93)
                begin
                    fn = FN_PAYLOAD;
                end
                else
                begin
                    fn = FN_END;
                end
            end
            else if (pick < 88 || (pick >= 96 && model_count == 8'd0))
            begin
                fn  = FN_PAYLOAD;
                dat = pick_payload();
                counted++;
            end
            else if (pick < 92)
            begin
                fn = FN_RX;
            end
            else if (pick < 96)
            begin
                fn = FN_TIMEOUT;
            end
            else
            begin
                fn = FN_END;
            end
            send_item(fn, dat, 1'b0, '0);
        end

        // Closing exchange: EOT path for scen 0..2, packet-ACK path otherwise
        scen = $urandom_range(0, 4);
        if (scen < 3)
        begin
            while (!(model_phase == PH_IDLE && model_count == 8'd0))
            begin
                if (model_phase == PH_WAIT_ACK)
                begin
                    send_item(FN_RX, ACK_BYTE, 1'b0, '0);
                end
                else
                begin
                    send_item(FN_PAYLOAD, pick_payload(), 1'b0, '0);
                end
            end
            send_item(FN_END, 8'($urandom), 1'b0, '0);
        end
        else
        begin
            while (model_phase != PH_WAIT_ACK)
            begin
                send_item(FN_PAYLOAD, pick_payload(), 1'b0, '0);
            end
        end

        bad_reply = ($urandom_range(0, 1) == 0) ? NAK_BYTE : 8'($urandom);
        if (bad_reply == ACK_BYTE)
        begin
            bad_reply = 8'h07;
        end
        case (scen)
            0:       send_item(FN_RX, ACK_BYTE, 1'b0, '0);
            1, 3:    send_item(FN_RX, bad_reply, 1'b0, '0);
            default: send_item(FN_TIMEOUT, 8'($urandom), 1'b0, '0);
        endcase

        // Closed state: everything is misuse
        repeat (4)
        begin
            send_item(2'($urandom), 8'($urandom), 1'b0, '0);
        end
        item_bus.valid <= 1'b0;

        // Drain
        while (expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
        begin
            $display("tb_xmodem_crc_packet_sender: done, clean");
        end
        else
        begin
            $display("tb_xmodem_crc_packet_sender: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
